@@ rtl/lrubr_pkg.sv @@
// Package: sizes, codes and the state-memory word for the buffer replacement block.
package lrubr_pkg;
    localparam int NBUF = 64;
    localparam int IW   = $clog2(NBUF);
    localparam int LW   = IW + 1;

    typedef logic [IW-1:0] t_idx;
    typedef logic [LW-1:0] t_lnk;

    localparam t_lnk LNK_NONE = {LW{1'b1}};

    localparam logic [1:0] MODE_ACCESS  = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_ALLOC   = 2'd2;
    localparam logic [1:0] MODE_PIN     = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_GRANTED = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // One entry of the buffer state memory.
    typedef struct packed {
        t_lnk prev;
        t_lnk next;
        t_lnk flink;
        logic on_free;
        logic pinned;
    } t_ent;
endpackage

@@ rtl/lrubr_mem.sv @@
// Buffer state memory: one write port, one registered read port, reset sweep.
module lrubr_mem import lrubr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_we,
    input  t_idx i_waddr,
    input  t_ent i_wdata,
    input  t_idx i_raddr,
    output t_ent o_rdata,
    output logic o_init_done
);
    t_ent           r_mem [NBUF];
    logic [IW:0]    r_clr;
    t_ent           w_init;

    always_comb begin
        w_init.prev    = LNK_NONE;
        w_init.next    = LNK_NONE;
        w_init.flink   = (r_clr[IW-1:0] == t_idx'(NBUF-1)) ? LNK_NONE
                         : t_lnk'({1'b0, r_clr[IW-1:0]} + t_lnk'(1));
        w_init.on_free = 1'b1;
        w_init.pinned  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (!r_clr[IW]) begin
            r_clr <= r_clr + (IW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr[IW]) begin
            r_mem[r_clr[IW-1:0]] <= w_init;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

    assign o_init_done = r_clr[IW];
endmodule

@@ rtl/lru_buffer_replacement_freelist.sv @@
// Top level: LRU buffer replacement with free list, sequenced over one state memory.
//
//  channel | dir | tdata (low bit up)                            | tuser
//  s_axis  | in  | mode[1:0], buffer_index[7:2], pin_value[8]     | -
//  m_axis  | out | granted_index[5:0], status[7:6], from_free[8], | -
//          |     | pass_count[40:9], alloc_count[72:41]          |
//
// Access and release unlink and relink entries: each link step is a memory read
// then a write; pin is one read and one write. Allocate walks entries one at a time,
// popping free buffers first and then rotating from the LRU end, up to NBUF rotations.
// After reset, a clearing pass over all NBUF entries runs before s_axis_tready rises.
// A result waits in the output register; the next beat is taken once it is taken.
module lru_buffer_replacement_freelist import lrubr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // mode, buffer_index, pin_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // granted, status, from_free, passes, allocs
);
    typedef enum logic [4:0] {
        S_IDLE, S_RD_B, S_DEC, S_UL_P, S_UL_PW, S_UL_N, S_UL_NW, S_UL_BW,
        S_PU_M, S_PU_MW, S_PU_BW, S_FP_BW, S_AL_F, S_AL_FW, S_AL_R, S_AL_RW,
        S_OUT
    } t_st;

    t_st   r_st;
    logic  [1:0] r_mode;
    logic  r_pv;
    t_idx  r_b;
    t_ent  r_e;
    t_lnk  r_mru, r_lru, r_fhead, r_ftail;
    t_idx  r_vc;
    logic [31:0] r_passes, r_allocs;
    logic [IW:0] r_tries;
    logic  r_rot;
    logic  [1:0] r_act;   // walk kind, as a mode code
    t_idx  r_gidx;
    logic  [1:0] r_stat;
    logic  r_ff;
    logic  r_ov;
    logic [79:0] r_od;

    logic  w_we;
    t_idx  w_wa, w_ra;
    t_ent  w_wd, w_rd;
    logic  w_init;
    logic  [1:0] w_mode;
    t_idx  w_bi;

    lrubr_mem u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(w_we), .i_waddr(w_wa),
        .i_wdata(w_wd), .i_raddr(w_ra), .o_rdata(w_rd), .o_init_done(w_init)
    );

    assign w_mode = s_axis_tdata[1:0];
    assign w_bi   = s_axis_tdata[7:2];
    assign s_axis_tready = (r_st == S_IDLE) && w_init && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    // Memory port control from state.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_b;
        w_wd = r_e;
        w_ra = r_b;
        case (r_st)
            S_IDLE:  w_ra = w_bi;
            S_UL_P:  w_ra = r_e.prev[IW-1:0];
            S_UL_PW: begin
                w_we = 1'b1; w_wa = r_e.prev[IW-1:0];
                w_wd = w_rd; w_wd.next = r_e.next;
            end
            S_UL_N:  w_ra = r_e.next[IW-1:0];
            S_UL_NW: begin
                w_we = 1'b1; w_wa = r_e.next[IW-1:0];
                w_wd = w_rd; w_wd.prev = r_e.prev;
            end
            S_PU_M:  w_ra = r_mru[IW-1:0];
            S_PU_MW: begin
                w_we = 1'b1; w_wa = r_mru[IW-1:0];
                w_wd = w_rd; w_wd.next = {1'b0, r_b};
            end
            S_PU_BW: begin
                w_we = 1'b1;
                w_wd = r_e; w_wd.prev = r_mru; w_wd.next = LNK_NONE;
                w_wd.flink = LNK_NONE; w_wd.on_free = 1'b0;
            end
            S_FP_BW: begin
                w_we = 1'b1;
                w_wd = r_e; w_wd.prev = LNK_NONE; w_wd.next = LNK_NONE;
                w_wd.flink = r_fhead; w_wd.on_free = 1'b1;
            end
            S_AL_F:  w_ra = r_fhead[IW-1:0];
            S_AL_R:  w_ra = r_lru[IW-1:0];
            S_DEC: begin
                if (r_mode == MODE_PIN) begin
                    w_we = 1'b1; w_wd = w_rd; w_wd.pinned = r_pv;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ov     <= 1'b0;
            r_mru    <= LNK_NONE;
            r_lru    <= LNK_NONE;
            r_fhead  <= '0;
            r_ftail  <= t_lnk'(NBUF-1);
            r_vc     <= '0;
            r_passes <= '0;
            r_allocs <= '0;
        end else begin
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_mode <= w_mode;
                        r_b    <= w_bi;
                        r_pv   <= s_axis_tdata[8];
                        r_gidx <= '0;
                        r_ff   <= 1'b0;
                        r_stat <= ST_IGNORED;
                        if (w_mode == MODE_ALLOC) begin
                            r_allocs <= r_allocs + 32'd1;
                            r_stat   <= ST_NONE;
                            r_act    <= MODE_ALLOC;
                            r_tries  <= '0;
                            r_st     <= (r_fhead[IW]) ? S_AL_R : S_AL_F;
                        end else begin
                            r_st <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    r_e <= w_rd;
                    r_rot <= 1'b0;
                    if (r_mode == MODE_PIN) begin
                        r_stat <= ST_DONE; r_st <= S_OUT;
                    end else if (w_rd.on_free ||
                                 (r_mode == MODE_RELEASE && w_rd.pinned)) begin
                        r_st <= S_OUT;
                    end else begin
                        r_stat <= ST_DONE;
                        r_act  <= r_mode;
                        r_st   <= S_UL_P;
                    end
                end
                // Unlink r_b using r_e links.
                S_UL_P:  r_st <= r_e.prev[IW] ? S_UL_N : S_UL_PW;
                S_UL_PW: r_st <= S_UL_N;
                S_UL_N:  r_st <= r_e.next[IW] ? S_UL_BW : S_UL_NW;
                S_UL_NW: r_st <= S_UL_BW;
                S_UL_BW: begin
                    if ({1'b0, r_b} == r_mru) r_mru <= r_e.prev;
                    if ({1'b0, r_b} == r_lru) r_lru <= r_e.next;
                    if (r_act == MODE_RELEASE) begin
                        r_st <= S_FP_BW;
                    end else begin
                        // Stale links after unlink: mru may now be r_e.prev.
                        r_st <= S_PU_M;
                    end
                end
                S_FP_BW: begin
                    if (r_fhead[IW]) r_ftail <= {1'b0, r_b};
                    r_fhead <= {1'b0, r_b};
                    r_st <= S_OUT;
                end
                S_PU_M:  r_st <= r_mru[IW] ? S_PU_BW : S_PU_MW;
                S_PU_MW: r_st <= S_PU_BW;
                S_PU_BW: begin
                    r_mru <= {1'b0, r_b};
                    if (r_lru[IW]) r_lru <= {1'b0, r_b};
                    if (r_act != MODE_ALLOC) begin
                        r_st <= S_OUT;
                    end else if (!r_e.pinned) begin
                        r_gidx <= r_b; r_stat <= ST_GRANTED; r_ff <= !r_rot;
                        r_st <= S_OUT;
                    end else if (!r_rot) begin
                        r_st <= r_fhead[IW] ? S_AL_R : S_AL_F;
                    end else begin
                        r_st <= (r_tries[IW] || r_lru[IW]) ? S_OUT : S_AL_R;
                    end
                end
                S_AL_F:  begin r_b <= r_fhead[IW-1:0]; r_st <= S_AL_FW; end
                S_AL_FW: begin
                    r_e <= w_rd; r_rot <= 1'b0;
                    r_fhead <= w_rd.flink;
                    r_st <= S_PU_M;
                end
                S_AL_R: begin
                    if (r_lru[IW] || r_tries[IW]) begin
                        r_st <= S_OUT;
                    end else begin
                        r_b <= r_lru[IW-1:0]; r_st <= S_AL_RW;
                    end
                end
                S_AL_RW: begin
                    r_e <= w_rd; r_rot <= 1'b1;
                    r_tries <= r_tries + (IW+1)'(1);
                    if (r_vc == t_idx'(NBUF-1)) begin
                        r_vc <= '0; r_passes <= r_passes + 32'd1;
                    end else begin
                        r_vc <= r_vc + t_idx'(1);
                    end
                    r_st <= S_UL_P;
                end
                S_OUT: begin
                    r_ov <= 1'b1;
                    r_od <= {7'd0, r_allocs, r_passes, r_ff, r_stat, r_gidx};
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/lrubr_checker.sv @@
// Port-level checker for the buffer replacement block, bound to the top level.
module lrubr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken before result");
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7:6] != 2'd1 |-> m_axis_tdata[8] == 1'b0)
        else $error("free flag set without grant");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result waits");
endmodule

bind lru_buffer_replacement_freelist lrubr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

@@ tb/testbench.sv @@
// Testbench for the LRU buffer replacement block: predicts each result and checks it.
module testbench;
    import lrubr_pkg::*;

    // Predicted state of the buffer pool.
    class pool_scoreboard;
        int prv[NBUF];
        int nxt[NBUF];
        int flk[NBUF];
        bit is_free[NBUF];
        bit pin[NBUF];
        int mru, lru, fhead, ftail;
        int unsigned victims, passes, allocs;
        logic [79:0] expected_results[$];
        int mismatches;
        int checked;
        int grants;
        int none_count;

        function new();
            for (int i = 0; i < NBUF; i++) begin
                prv[i] = -1;
                nxt[i] = -1;
                flk[i] = (i + 1 < NBUF) ? i + 1 : -1;
                is_free[i] = 1;
                pin[i] = 0;
            end
            mru = -1;
            lru = -1;
            fhead = 0;
            ftail = NBUF - 1;
            victims = 0;
            passes = 0;
            allocs = 0;
            mismatches = 0;
            checked = 0;
            grants = 0;
            none_count = 0;
        endfunction

        function void unlink(int b);
            int p;
            int n;
            p = prv[b];
            n = nxt[b];
            if (p >= 0) nxt[p] = n;
            if (n >= 0) prv[n] = p;
            if (b == mru) mru = p;
            if (b == lru) lru = n;
            prv[b] = -1;
            nxt[b] = -1;
        endfunction

        function void make_mru(int b);
            prv[b] = mru;
            nxt[b] = -1;
            if (mru >= 0) nxt[mru] = b;
            mru = b;
            if (lru < 0) lru = b;
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(logic [1:0] mode, logic [5:0] idx, logic pv);
            int b;
            logic [5:0] granted;
            logic [1:0] status;
            logic from_free;
            granted = '0;
            status = ST_IGNORED;
            from_free = 0;
            if (mode == MODE_ALLOC) begin
                allocs++;
                status = ST_NONE;
                while (fhead >= 0) begin
                    b = fhead;
                    fhead = flk[b];
                    flk[b] = -1;
                    is_free[b] = 0;
                    make_mru(b);
                    if (!pin[b]) begin
                        granted = b[5:0];
                        status = ST_GRANTED;
                        from_free = 1;
                        break;
                    end
                end
                if (status != ST_GRANTED) begin
                    for (int t = 0; t < NBUF; t++) begin
                        b = lru;
                        if (b < 0) break;
                        unlink(b);
                        make_mru(b);
                        victims++;
                        if (victims >= NBUF) begin
                            passes++;
                            victims = 0;
                        end
                        if (!pin[b]) begin
                            granted = b[5:0];
                            status = ST_GRANTED;
                            break;
                        end
                    end
                end
                if (status == ST_GRANTED) grants++;
                else none_count++;
            end else begin
                b = idx;
                if (mode == MODE_PIN) begin
                    pin[b] = pv;
                    status = ST_DONE;
                end else if (!is_free[b]) begin
                    if (mode == MODE_ACCESS) begin
                        unlink(b);
                        make_mru(b);
                        status = ST_DONE;
                    end else if (!pin[b]) begin
                        unlink(b);
                        flk[b] = fhead;
                        if (fhead < 0) ftail = b;
                        fhead = b;
                        is_free[b] = 1;
                        status = ST_DONE;
                    end
                end
            end
            expected_results.push_back({7'd0, allocs, passes, from_free, status, granted});
        endfunction

        function void check_result(logic [79:0] got);
            logic [79:0] want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got[5:0] !== want[5:0] || got[7:6] !== want[7:6] || got[8] !== want[8]
                || got[40:9] !== want[40:9] || got[72:41] !== want[72:41]
                || got[79:73] !== 7'd0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: granted %0d/%0d status %0d/%0d free %0d/%0d ",
                             want[5:0], got[5:0], want[7:6], got[7:6], want[8], got[8],
                             "pass %0d/%0d alloc %0d/%0d (exp/got)",
                             want[40:9], got[40:9], want[72:41], got[72:41]);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // mode, buffer_index, pin_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [79:0] m_axis_tdata;       // granted, status, from_free, passes, allocs

    pool_scoreboard board;
    bit hold_off_long = 0;
    int unsigned sent = 0;

    lru_buffer_replacement_freelist u_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    always #2 i_clk = ~i_clk;

    // Offer one request; hold it until the beat is taken.
    task automatic send_request(logic [1:0] mode, logic [5:0] idx, logic pv);
        s_axis_tdata <= {7'd0, pv, idx, mode};
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(mode, idx, pv);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    // Mostly access, allocate and pin on indices 0 to hot (sometimes any index), with some releases.
    task automatic send_random(int hot);
        int r;
        logic [1:0] mode;
        logic [5:0] idx;
        r = $urandom_range(0, 99);
        if (r < 35) mode = MODE_ALLOC;
        else if (r < 60) mode = MODE_ACCESS;
        else if (r < 80) mode = MODE_RELEASE;
        else mode = MODE_PIN;
        idx = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, hot));
        send_request(mode, idx, ($urandom_range(0, 2) == 0));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial begin
        int cnt;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_long) begin
                m_axis_tready <= 0;
                for (cnt = 0; cnt < 400; cnt++) @(negedge i_clk);
                hold_off_long = 0;
            end
            if (sent < 300 || (sent > 900 && sent < 1100)) m_axis_tready <= 1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        #50000000;
        $display("lru_buffer_replacement_freelist test failed");
        $finish;
    end

    initial begin
        int waited;
        board = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, every mode, the special cases.
        send_request(MODE_ACCESS, 6'd0, 0);        // access to a free buffer
        send_request(MODE_RELEASE, 6'd63, 0);      // release of a free buffer
        send_request(MODE_PIN, 6'd0, 1);           // pin a free buffer
        send_request(MODE_ALLOC, 6'd0, 0);         // pinned pop still joins the list
        send_request(MODE_ACCESS, 6'd1, 0);
        send_request(MODE_RELEASE, 6'd0, 0);       // release of a pinned buffer
        send_request(MODE_RELEASE, 6'd1, 1);
        send_request(MODE_ACCESS, 6'd63, 1);
        send_request(MODE_PIN, 6'd63, 0);
        // Pin everything, drain the free list: allocation must give up.
        for (int i = 0; i < NBUF; i++) send_request(MODE_PIN, i[5:0], 1);
        for (int i = 0; i < 3; i++) send_request(MODE_ALLOC, 6'd63, 1);
        for (int i = 0; i < NBUF; i++) send_request(MODE_PIN, i[5:0], 0);
        send_request(MODE_ACCESS, 6'd42, 0);
        send_request(MODE_RELEASE, 6'd42, 0);
        send_request(MODE_PIN, 6'd5, 1);
        send_request(MODE_ALLOC, 6'd0, 0);

        for (int n = 0; n < 1100; n++) begin
            if (n == 700) hold_off_long = 1;
            if (n > 700 && n < 760) send_random(15);  // keep offering while stalled
            else begin
                if ($urandom_range(0, 7) == 0 && !(n > 900 && n < 1100)) idle_gap();
                // Phases: small working set, then full range.
                send_random(n < 800 ? 15 : 63);
            end
            // Occasionally pin most of the pool to drive rotation passes.
            if (n % 400 == 399) begin
                for (int i = 0; i < NBUF; i++) send_request(MODE_PIN, i[5:0], (i != 62));
                for (int i = 0; i < 4; i++) send_request(MODE_ALLOC, 6'd0, 0);
                for (int i = 0; i < NBUF; i++) send_request(MODE_PIN, i[5:0], 0);
            end
        end
        s_axis_tvalid <= 0;

        waited = 0;
        while (board.expected_results.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        $display("sent %0d requests, checked %0d results: %0d grants, %0d all-pinned refusals",
                 sent, board.checked, board.grants, board.none_count);
        $display("mismatches: %0d, results still pending: %0d",
                 board.mismatches, board.expected_results.size());
        if (board.mismatches == 0 && board.expected_results.size() == 0)
            $display("lru_buffer_replacement_freelist test passed");
        else
            $display("lru_buffer_replacement_freelist test failed");
        $finish;
    end
endmodule
